FILE: rtl/arm_forward_kinematics_check_core_assert.svh
// Assertion macros for the arm kinematics core
`ifndef ARM_FORWARD_KINEMATICS_CHECK_CORE_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_CHECK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define AFK_ASSERT_IMPL(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
	else $error("afk assertion failed");
`define AFK_ASSERT_NEXT(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
	else $error("afk assertion failed");
`else
`define AFK_ASSERT_IMPL(lbl, ck, rn, pre, post)
`define AFK_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

FILE: rtl/afk_pkg.sv
`default_nettype none
package afk_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 24;
	localparam logic signed [17:0] PI_Q12      = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
	localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
	localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188014;

	// register indexes
	localparam logic [2:0] REG_ARM_LENGTHS = 3'd0;
	localparam logic [2:0] REG_ZERO_POS    = 3'd1;
	localparam logic [2:0] REG_ANGLE_SCL   = 3'd2;
	localparam logic [2:0] REG_CART_MIN    = 3'd3;
	localparam logic [2:0] REG_CART_MAX    = 3'd4;
	localparam logic [2:0] REG_JOINT_MIN   = 3'd5;
	localparam logic [2:0] REG_JOINT_MAX   = 3'd6;

	// limit status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_DEPTH_LO    = 4'd1;
	localparam logic [3:0] ST_JOINT_BELOW = 4'd7;
	localparam logic [3:0] ST_JOINT_ABOVE = 4'd8;

	typedef logic signed [26:0] cval_t;
	typedef logic signed [27:0] zval_t;

	function automatic zval_t atan_step(input int i);
		case (i)
			0: atan_step = 28'sd13176795;
			1: atan_step = 28'sd7778716;
			2: atan_step = 28'sd4110060;
			3: atan_step = 28'sd2086331;
			4: atan_step = 28'sd1047214;
			5: atan_step = 28'sd524117;
			6: atan_step = 28'sd262123;
			7: atan_step = 28'sd131069;
			default: atan_step = zval_t'(28'sd1 <<< (24 - i));
		endcase
	endfunction

	function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
		if (v > 64'sd524287) sat20 = 20'sd524287;
		else if (v < -64'sd524288) sat20 = -20'sd524288;
		else sat20 = v[19:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) sat16 = 16'sd32767;
		else if (v < -64'sd32768) sat16 = -16'sd32768;
		else sat16 = v[15:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/arm_forward_kinematics_check_core.sv
// Throughput: one item per cycle; every stage register holds while the
// output result waits, so the whole pipe advances together.
// The CORDIC rotation chain, one stage per step, sets the latency.
// Reset (arst_n low, asynchronous) clears all valid bits and the configuration
// registers to 0; pipeline data registers are not reset.
`default_nettype none
`include "arm_forward_kinematics_check_core_assert.svh"
module arm_forward_kinematics_check_core
	import afk_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [59:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// base_count[15:0], shoulder_count[31:16], elbow_count[47:32]
	input  wire logic [47:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tip_depth[19:0], tip_lateral[39:20], tip_height[59:40], base_angle[75:60],
	// shoulder_angle[91:76], elbow_angle[107:92], limit_status[111:108],
	// fault_joint[113:112], zero fill[119:114]
	output logic [119:0]      m_tdata
);
	localparam int N = CORDIC_STEPS;

	logic [47:0] arm_q, zero_q, scl_q, jmin_q, jmax_q;
	logic [59:0] cmin_q, cmax_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q <= '0; zero_q <= '0; scl_q <= '0; jmin_q <= '0; jmax_q <= '0;
			cmin_q <= '0; cmax_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ARM_LENGTHS: arm_q  <= cfg_wdata[47:0];
				REG_ZERO_POS:    zero_q <= cfg_wdata[47:0];
				REG_ANGLE_SCL:   scl_q  <= cfg_wdata[47:0];
				REG_CART_MIN:    cmin_q <= cfg_wdata;
				REG_CART_MAX:    cmax_q <= cfg_wdata;
				REG_JOINT_MIN:   jmin_q <= cfg_wdata[47:0];
				REG_JOINT_MAX:   jmax_q <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: count offset times scale
	logic               v_s1;
	logic signed [32:0] prod_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				prod_s1[j] <= ($signed({1'b0, s_tdata[16*j +: 16]}) -
					$signed({1'b0, zero_q[16*j +: 16]})) * $signed(scl_q[16*j +: 16]);
		end
	end

	// stage 2: round to Q3.12, saturate, form elbow minus shoulder
	logic               v_s2;
	logic signed [15:0] ang_s2 [3];
	logic signed [16:0] diff_s2;
	logic signed [15:0] ang_c [3];
	always_comb begin
		for (int j = 0; j < 3; j++)
			ang_c[j] = sat16((64'(prod_s1[j]) + 64'sd128) >>> 8);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2  <= ang_c;
			diff_s2 <= 17'(ang_c[2]) - 17'(ang_c[1]);
		end
	end

	// range reduction to [-pi/2, pi/2] with sign flag
	function automatic void reduce(input logic signed [16:0] a_in, output zval_t z,
		output logic neg);
		logic signed [17:0] a;
		a = 18'(a_in);
		for (int k = 0; k < 3; k++)
			if (a > PI_Q12) a = a - TWO_PI_Q12;
		for (int k = 0; k < 3; k++)
			if (a < -PI_Q12) a = a + TWO_PI_Q12;
		neg = 1'b0;
		if (a > HALF_PI_Q12) begin
			a = a - PI_Q12; neg = 1'b1;
		end else if (a < -HALF_PI_Q12) begin
			a = a + PI_Q12; neg = 1'b1;
		end
		z = zval_t'(a) <<< 12;
	endfunction

	// CORDIC chain: index 0 is stage 3, index k holds the result of k steps
	cval_t              cx_s [N+1][3];
	cval_t              cy_s [N+1][3];
	zval_t              cz_s [N+1][3];
	logic [2:0]         cn_s [N+1];
	logic signed [15:0] ca_s [N+1][3];
	logic [N:0]         cv_s;
	zval_t              z_red [3];
	logic [2:0]         n_red;

	always_comb begin
		reduce(17'(ang_s2[1]), z_red[0], n_red[0]);
		reduce(diff_s2,        z_red[1], n_red[1]);
		reduce(17'(ang_s2[0]), z_red[2], n_red[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s <= '0;
		else if (en) cv_s <= {cv_s[N-1:0], v_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				cx_s[0][j] <= CORDIC_GAIN;
				cy_s[0][j] <= '0;
				cz_s[0][j] <= z_red[j];
			end
			cn_s[0] <= n_red;
			ca_s[0] <= ang_s2;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (!cz_s[k][j][27]) begin
						cx_s[k+1][j] <= cx_s[k][j] - (cy_s[k][j] >>> k);
						cy_s[k+1][j] <= cy_s[k][j] + (cx_s[k][j] >>> k);
						cz_s[k+1][j] <= cz_s[k][j] - atan_step(k);
					end else begin
						cx_s[k+1][j] <= cx_s[k][j] + (cy_s[k][j] >>> k);
						cy_s[k+1][j] <= cy_s[k][j] - (cx_s[k][j] >>> k);
						cz_s[k+1][j] <= cz_s[k][j] + atan_step(k);
					end
				end
				cn_s[k+1] <= cn_s[k];
				ca_s[k+1] <= ca_s[k];
			end
		end
	end

	// stage 4: apply sign flip, multiply lengths by sine and cosine
	cval_t sn [3], cs [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sn[j] = cn_s[N][j] ? -cy_s[N][j] : cy_s[N][j];
			cs[j] = cn_s[N][j] ? -cx_s[N][j] : cx_s[N][j];
		end
	end
	logic signed [16:0] l1, l2, hh;
	assign l1 = $signed({1'b0, arm_q[15:0]});
	assign l2 = $signed({1'b0, arm_q[31:16]});
	assign hh = $signed({1'b0, arm_q[47:32]});

	logic               v_s4;
	logic signed [43:0] p_s4 [3], q_s4 [3];
	cval_t              st_s4, ct_s4;
	logic signed [15:0] ang_s4 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= cv_s[N];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s4[0] <= l1 * cs[0];
			p_s4[1] <= l2 * cs[1];
			p_s4[2] <= hh * sn[1];
			q_s4[0] <= l1 * sn[0];
			q_s4[1] <= l2 * sn[1];
			q_s4[2] <= hh * cs[1];
			st_s4   <= sn[2];
			ct_s4   <= cs[2];
			ang_s4  <= ca_s[N];
		end
	end

	// stage 5: sum into reach and height
	logic signed [45:0] rsum, vsum;
	assign rsum = 46'(p_s4[0]) + 46'(p_s4[1]) + 46'(p_s4[2]);
	assign vsum = 46'(q_s4[0]) - 46'(q_s4[1]) + 46'(q_s4[2]);

	logic               v_s5;
	logic signed [29:0] r_s5;
	logic signed [19:0] ht_s5;
	cval_t              st_s5, ct_s5;
	logic signed [15:0] ang_s5 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s5   <= 30'((rsum + 46'sd32768) >>> 16);
			ht_s5  <= sat20(64'((vsum + 46'sd8388608) >>> 24));
			st_s5  <= st_s4;
			ct_s5  <= ct_s4;
			ang_s5 <= ang_s4;
		end
	end

	// stage 6: project reach onto depth and lateral
	logic               v_s6;
	logic signed [56:0] md_s6, ml_s6;
	logic signed [19:0] ht_s6;
	logic signed [15:0] ang_s6 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			md_s6  <= r_s5 * st_s5;
			ml_s6  <= r_s5 * ct_s5;
			ht_s6  <= ht_s5;
			ang_s6 <= ang_s5;
		end
	end

	// stage 7: round and saturate coordinates
	logic               v_s7;
	logic signed [19:0] crd_s7 [3];
	logic signed [15:0] ang_s7 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s7[0] <= sat20(64'((md_s6 + 57'sd2147483648) >>> 32));
			crd_s7[1] <= sat20(64'((ml_s6 + 57'sd2147483648) >>> 32));
			crd_s7[2] <= ht_s6;
			ang_s7    <= ang_s6;
		end
	end

	// limit check, first violation wins
	logic [3:0] status;
	logic [1:0] fj;
	always_comb begin
		status = ST_OK;
		fj     = 2'd0;
		for (int j = 0; j < 3; j++) begin
			if (status == ST_OK) begin
				if ($signed(cmin_q[20*j +: 20]) > crd_s7[j])
					status = ST_DEPTH_LO + 4'(2*j);
				else if ($signed(cmax_q[20*j +: 20]) < crd_s7[j])
					status = ST_DEPTH_LO + 4'(2*j + 1);
			end
		end
		for (int j = 0; j < 3; j++) begin
			if (status == ST_OK) begin
				if ($signed(jmin_q[16*j +: 16]) > ang_s7[j]) begin
					status = ST_JOINT_BELOW; fj = 2'(j);
				end else if ($signed(jmax_q[16*j +: 16]) < ang_s7[j]) begin
					status = ST_JOINT_ABOVE; fj = 2'(j);
				end
			end
		end
	end

	// stage 8: output register
	logic               v_s8;
	logic signed [19:0] crd_s8 [3];
	logic signed [15:0] ang_s8 [3];
	logic [3:0]         st_s8;
	logic [1:0]         fj_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s8 <= crd_s7;
			ang_s8 <= ang_s7;
			st_s8  <= status;
			fj_s8  <= fj;
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = {6'd0, fj_s8, st_s8, ang_s8[2], ang_s8[1], ang_s8[0],
		crd_s8[2], crd_s8[1], crd_s8[0]};

	`AFK_ASSERT_IMPL(a_status_range, clk, arst_n, v_s8, st_s8 <= ST_JOINT_ABOVE)
	`AFK_ASSERT_IMPL(a_fj_code, clk, arst_n, v_s8 && fj_s8 != 2'd0, st_s8 >= ST_JOINT_BELOW)
	`AFK_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en, $stable(cv_s) && $stable(v_s8))
	`AFK_ASSERT_NEXT(a_enter, clk, arst_n, s_tvalid && s_tready, v_s1)
endmodule
`default_nettype wire

FILE: tb/arm_forward_kinematics_check_core_test.sv
`timescale 1ns / 1ps
module arm_forward_kinematics_check_core_test;
	import afk_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam longint ATAN_HEAD[8] = '{13176795, 7778716, 4110060, 2086331,
		1047214, 524117, 262123, 131069};
	localparam int FOFF[8] = '{0, 20, 40, 60, 76, 92, 108, 112};
	localparam int FW[8] = '{20, 20, 20, 16, 16, 16, 4, 2};

	typedef enum int {CFG_NOMINAL, CFG_FULL_HI, CFG_FULL_LO, CFG_SCRAMBLED} cfg_kind_e;

	// predicts tip position, joint angles and limit status per transfer
	class fk_scoreboard;
		logic [59:0] regs[7];
		logic [119:0] tip_q[$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [59:0] v);
			if (idx == REG_CART_MIN || idx == REG_CART_MAX)
				regs[idx] = v;
			else if (idx <= REG_JOINT_MAX)
				regs[idx] = {12'd0, v[47:0]};
		endfunction

		function longint rnd(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint satw(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function void sin_cos(input longint a, output longint s, output longint c);
			longint x, y, z, t, step;
			bit flip;
			x = CORDIC_GAIN;
			y = 0;
			flip = 0;
			while (a > PI_Q12) a -= TWO_PI_Q12;
			while (a < -PI_Q12) a += TWO_PI_Q12;
			// fold into the right half plane
			if (a > HALF_PI_Q12) begin
				a -= PI_Q12;
				flip = 1;
			end else if (a < -HALF_PI_Q12) begin
				a += PI_Q12;
				flip = 1;
			end
			z = a * 4096;
			for (int i = 0; i < STEPS && i < 24; i++) begin
				step = (i < 8) ? ATAN_HEAD[i] : (longint'(1) <<< (24 - i));
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= step;
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += step;
				end
				x = t;
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function void note_input(logic [47:0] d);
			longint ang[3], coord[3], l1, l2, h, sa, ca, sb, cb, st, ct, r, v, cnt, zero;
			longint scl, mn, mx;
			logic signed [15:0] s16;
			logic signed [19:0] s20;
			logic [3:0] status;
			logic [1:0] fj;
			logic [119:0] e;
			for (int j = 0; j < 3; j++) begin
				cnt = d[16*j +: 16];
				zero = regs[REG_ZERO_POS][16*j +: 16];
				s16 = regs[REG_ANGLE_SCL][16*j +: 16];
				scl = s16;
				ang[j] = satw(rnd((cnt - zero) * scl, 8), 16);
			end
			l1 = regs[REG_ARM_LENGTHS][15:0];
			l2 = regs[REG_ARM_LENGTHS][31:16];
			h = regs[REG_ARM_LENGTHS][47:32];
			sin_cos(ang[1], sa, ca);
			sin_cos(ang[2] - ang[1], sb, cb);
			sin_cos(ang[0], st, ct);
			r = rnd(l1 * ca + l2 * cb + h * sb, 16);
			v = l1 * sa - l2 * sb + h * cb;
			coord[2] = satw(rnd(v, 24), 20);
			coord[0] = satw(rnd(r * st, 32), 20);
			coord[1] = satw(rnd(r * ct, 32), 20);
			// cartesian limits first, then joints; first violation wins
			status = ST_OK;
			fj = 0;
			for (int j = 0; j < 3 && status == ST_OK; j++) begin
				s20 = regs[REG_CART_MIN][20*j +: 20];
				mn = s20;
				s20 = regs[REG_CART_MAX][20*j +: 20];
				mx = s20;
				if (mn > coord[j]) status = ST_DEPTH_LO + 4'(2 * j);
				else if (mx < coord[j]) status = ST_DEPTH_LO + 4'(2 * j + 1);
			end
			for (int j = 0; j < 3 && status == ST_OK; j++) begin
				s16 = regs[REG_JOINT_MIN][16*j +: 16];
				mn = s16;
				s16 = regs[REG_JOINT_MAX][16*j +: 16];
				mx = s16;
				if (mn > ang[j]) begin
					status = ST_JOINT_BELOW;
					fj = 2'(j);
				end else if (mx < ang[j]) begin
					status = ST_JOINT_ABOVE;
					fj = 2'(j);
				end
			end
			e = '0;
			for (int j = 0; j < 3; j++) begin
				e[20*j +: 20] = coord[j][19:0];
				e[60 + 16*j +: 16] = ang[j][15:0];
			end
			e[111:108] = status;
			e[113:112] = fj;
			tip_q.push_back(e);
		endfunction

		function void check_result(logic [119:0] a);
			string names[8] = '{"tip_depth", "tip_lateral", "tip_height", "base_angle",
				"shoulder_angle", "elbow_angle", "limit_status", "fault_joint"};
			logic [119:0] e, m;
			if (tip_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				errors++;
				return;
			end
			e = tip_q.pop_front();
			for (int k = 0; k < 8; k++) begin
				m = (120'd1 << FW[k]) - 1;
				if (((e >> FOFF[k]) & m) != ((a >> FOFF[k]) & m)) begin
					$display("%0t: %s mismatch, expected %h, actual %h", $time, names[k],
						(e >> FOFF[k]) & m, (a >> FOFF[k]) & m);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [59:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [119:0] m_tdata;

	fk_scoreboard sb;
	int sender_idle = 26;
	int receiver_idle = 47;
	int items = 0;
	longint cycles = 0;

	arm_forward_kinematics_check_core #(.CORDIC_STEPS(STEPS)) dut (.*);

	always #1 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// check each output transfer, then randomize backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	task automatic send_item(logic [47:0] d);
		// idle cycle by cycle at the current sender rate
		while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_input(d);
		items++;
		// idle schedule: sender light, then receiver light, then none
		if (items < 567) begin
			sender_idle = 26;
			receiver_idle = 47;
		end else if (items < 1134) begin
			sender_idle = 47;
			receiver_idle = 26;
		end else begin
			sender_idle = 0;
			receiver_idle = 0;
		end
	endtask

	// hold off until every prediction is consumed and the pipe is empty
	task automatic drain();
		s_tvalid <= 0;
		while (sb.tip_q.size() > 0) @(posedge clk);
		repeat (STEPS + 16) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [59:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic logic [19:0] rand_coord(int span);
		return 20'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic configure(cfg_kind_e kind);
		logic [59:0] v[7];
		case (kind)
			CFG_NOMINAL: begin
				v[REG_ARM_LENGTHS] = {16'd160, 16'd1600, 16'd1600};
				v[REG_ZERO_POS] = {16'd2048, 16'd2048, 16'd2048};
				v[REG_ANGLE_SCL] = {16'd768, -16'sd768, 16'd768};
				v[REG_CART_MIN] = {rand_coord(4000), rand_coord(4000), rand_coord(4000)};
				v[REG_CART_MAX] = {rand_coord(4000), rand_coord(4000), rand_coord(4000)};
				v[REG_CART_MIN] = v[REG_CART_MIN] - 60'h0000c8003200c80;
				v[REG_CART_MAX] = v[REG_CART_MAX] + 60'h0000c8003200c80;
				v[REG_JOINT_MIN] = {16'(-$urandom_range(0, 9000)), 16'(-$urandom_range(0, 9000)),
					16'(-$urandom_range(0, 9000))};
				v[REG_JOINT_MAX] = {16'($urandom_range(0, 9000)), 16'($urandom_range(0, 9000)),
					16'($urandom_range(0, 9000))};
			end
			CFG_FULL_HI: begin
				v[REG_ARM_LENGTHS] = {3{16'hffff}};
				v[REG_ZERO_POS] = {3{16'hffff}};
				v[REG_ANGLE_SCL] = {3{16'h7fff}};
				v[REG_CART_MIN] = {3{20'h80000}};
				v[REG_CART_MAX] = {3{20'h7ffff}};
				v[REG_JOINT_MIN] = {3{16'h8000}};
				v[REG_JOINT_MAX] = {3{16'h7fff}};
			end
			CFG_FULL_LO: begin
				// inverted joint limits and a collapsed cartesian box
				v[REG_ARM_LENGTHS] = {16'hffff, 16'd0, 16'hffff};
				v[REG_ZERO_POS] = '0;
				v[REG_ANGLE_SCL] = {3{16'h8000}};
				v[REG_CART_MIN] = '0;
				v[REG_CART_MAX] = '0;
				v[REG_JOINT_MIN] = {3{16'h7fff}};
				v[REG_JOINT_MAX] = {3{16'h8000}};
			end
			default: begin
				foreach (v[i]) v[i] = {28'($urandom), $urandom};
			end
		endcase
		foreach (v[i]) write_reg(3'(i), v[i]);
		// writes to the unused index must be ignored
		write_reg(3'd7, {28'($urandom), $urandom});
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_count(logic [15:0] zero);
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return $urandom_range(1) ? 16'hffff : 16'h0000;
		if (pick <= 5) return zero + 16'($urandom_range(0, 6000)) - 16'd3000;
		return 16'($urandom);
	endfunction

	task automatic run_random(int n);
		logic [47:0] d;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < 3; j++)
				d[16*j +: 16] = rand_count(sb.regs[REG_ZERO_POS][16*j +: 16]);
			send_item(d);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// registers still at reset
		send_item(48'h0);
		send_item({3{16'hffff}});
		send_item({16'h1234, 16'h8000, 16'h7fff});
		drain();

		// directed extremes on a nominal arm
		configure(CFG_NOMINAL);
		send_item({3{16'd2048}});
		send_item(48'h0);
		send_item({3{16'hffff}});
		send_item({16'h0000, 16'hffff, 16'h0000});
		send_item({16'hffff, 16'h0000, 16'hffff});
		send_item({16'd2048, 16'd0, 16'd4096});
		send_item({16'd4096, 16'd4096, 16'd0});
		for (int i = 0; i < 10; i++)
			send_item({16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
				16'($urandom_range(0, 4096))});
		drain();
		configure(CFG_FULL_HI);
		send_item(48'h0);
		send_item({3{16'hffff}});
		drain();
		configure(CFG_FULL_LO);
		send_item(48'h0);
		send_item({3{16'hffff}});
		drain();

		// random phases across several settings
		configure(CFG_NOMINAL);
		run_random(200);
		drain();
		run_random(250);
		drain();
		configure(CFG_SCRAMBLED);
		run_random(250);
		drain();
		configure(CFG_NOMINAL);
		run_random(250);
		drain();
		configure(CFG_FULL_HI);
		run_random(200);
		drain();
		configure(CFG_FULL_LO);
		run_random(200);
		drain();
		configure(CFG_SCRAMBLED);
		run_random(150);
		drain();
		configure(CFG_NOMINAL);
		run_random(200);
		drain();

		if (sb.errors == 0 && sb.tip_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/afk_pkg.sv
rtl/arm_forward_kinematics_check_core.sv
tb/arm_forward_kinematics_check_core_test.sv
